### rtl/core/ulfe_pkg.sv
// ----------------------------------------------------------------------------
// ulfe_pkg
// Shared types and constants for the unique entry list with oldest-first
// eviction.
// ----------------------------------------------------------------------------
package ulfe_pkg;

  localparam int KEY_W       = 48;
  localparam int ADDR_W      = 32;
  localparam int PORT_W      = 16;
  localparam int IDX_W       = 6;
  localparam int OCC_W       = 7;
  localparam int OCC_MAX     = 127;
  localparam int CAPACITY_DF = 64;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_LOOKUP = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_READ   = 2'd3
  } act_t;

  // per-cell update control for a pending request
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

  function automatic logic key_is_null(input logic [KEY_W-1:0] k);
    key_is_null = (k[KEY_W-1:PORT_W] == '0) || (k[PORT_W-1:0] == '0);
  endfunction

endpackage

### rtl/core/ulfe_cell.sv
// ----------------------------------------------------------------------------
// ulfe_cell
// One list slot: holds or loads a key, compares it against the request key and
// takes the key of the slot above when the list closes up or shifts.
// ----------------------------------------------------------------------------
module ulfe_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cmp_en,
  input  logic [ulfe_pkg::KEY_W-1:0]  cmp_key,
  input  ulfe_pkg::cell_ctrl_t        ctrl,
  input  logic [ulfe_pkg::KEY_W-1:0]  load_key,
  input  logic [ulfe_pkg::KEY_W-1:0]  nbr_key,
  output logic [ulfe_pkg::KEY_W-1:0]  key_o,
  output logic                        match_o
);

  logic [ulfe_pkg::KEY_W-1:0] key_r;
  logic [ulfe_pkg::KEY_W-1:0] key_nxt;
  logic                       match_r;

  always_comb begin
    key_nxt = key_r;
    if (ctrl.load) begin
      key_nxt = load_key;
    end else if (ctrl.shift) begin
      key_nxt = nbr_key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else begin
      key_r <= key_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_en) begin
      match_r <= (key_r == cmp_key);
    end
  end

  assign key_o   = key_r;
  assign match_o = match_r;

endmodule

### rtl/core/unique_entry_list_fifo_evict.sv
// ----------------------------------------------------------------------------
// unique_entry_list_fifo_evict
// Packed list of unique non-null keys held in a row of slot cells, with
// insert (oldest dropped when full), lookup, remove at index and read.
// ----------------------------------------------------------------------------
// result path: the request and the per-cell compares are registered on accept;
//   the result and out_valid are registered from them while busy is high
// a new request is refused while busy; busy is high for the cycle after
//   accept, while the registered per-cell compares are reduced and the row
//   is updated
// reset: synchronous, clears every slot to null and the fill count to zero
// the receiver cannot stall; each result is shown for exactly one cycle
module unique_entry_list_fifo_evict #(
  parameter int CAPACITY = ulfe_pkg::CAPACITY_DF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_action,
  input  logic [ulfe_pkg::KEY_W-1:0]  in_host_key,
  input  logic [ulfe_pkg::IDX_W-1:0]  in_slot_index,
  output logic                        out_valid,
  output logic                        out_accepted,
  output logic                        out_found,
  output logic [ulfe_pkg::KEY_W-1:0]  out_entry_key,
  output logic                        out_entry_present,
  output logic [ulfe_pkg::OCC_W-1:0]  out_occupancy
);

  localparam int FILL_W = $clog2(CAPACITY + 1);
  localparam int IW     = (FILL_W > ulfe_pkg::IDX_W) ? FILL_W : ulfe_pkg::IDX_W;
  localparam int OW     = (FILL_W > ulfe_pkg::OCC_W) ? FILL_W : ulfe_pkg::OCC_W;

  logic                       pend_r;
  logic [1:0]                 req_act_r;
  logic [ulfe_pkg::KEY_W-1:0] req_key_r;
  logic [ulfe_pkg::IDX_W-1:0] req_idx_r;
  logic [FILL_W-1:0]          fill_r;
  logic [FILL_W-1:0]          fill_nxt;

  logic                       out_valid_r;
  logic                       acc_r;
  logic                       fnd_r;
  logic [ulfe_pkg::KEY_W-1:0] ekey_r;
  logic                       pres_r;
  logic [ulfe_pkg::OCC_W-1:0] occ_r;

  logic                       acc_nxt;
  logic                       fnd_nxt;
  logic [ulfe_pkg::KEY_W-1:0] ekey_nxt;
  logic                       pres_nxt;
  logic [ulfe_pkg::OCC_W-1:0] occ_nxt;

  logic                       accept;
  logic                       req_null;
  logic                       any_match;
  logic                       idx_ok;
  logic                       do_load;
  logic                       do_evict;
  logic                       do_remove;
  logic [IW-1:0]              idx_ext;
  logic [IW-1:0]              fill_ext;
  logic [OW-1:0]              occ_ext;
  logic [ulfe_pkg::KEY_W-1:0] top_in;
  logic [ulfe_pkg::KEY_W-1:0] rd_key;
  ulfe_pkg::act_t             act;

  logic [ulfe_pkg::KEY_W-1:0] cell_key [CAPACITY];
  logic [ulfe_pkg::KEY_W-1:0] cell_nbr [CAPACITY];
  logic [CAPACITY-1:0]        cell_match;
  ulfe_pkg::cell_ctrl_t       cell_ctrl [CAPACITY];

  assign accept = start && !busy;
  assign busy   = pend_r;

  // ---------------------------------------------------------------- cell row
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == CAPACITY - 1) begin : g_top
      assign cell_nbr[g] = top_in;
    end else begin : g_mid
      assign cell_nbr[g] = cell_key[g+1];
    end

    ulfe_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmp_en   (accept),
      .cmp_key  (in_host_key),
      .ctrl     (cell_ctrl[g]),
      .load_key (req_key_r),
      .nbr_key  (cell_nbr[g]),
      .key_o    (cell_key[g]),
      .match_o  (cell_match[g])
    );
  end

  // ------------------------------------------------------- request decode
  assign act       = ulfe_pkg::act_t'(req_act_r);
  assign req_null  = ulfe_pkg::key_is_null(req_key_r);
  assign any_match = |cell_match;
  assign idx_ext   = IW'(req_idx_r);
  assign fill_ext  = IW'(fill_r);
  assign idx_ok    = idx_ext < fill_ext;

  // one-hot read-out across the row
  always_comb begin
    rd_key = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (idx_ext == IW'(i)) begin
        rd_key = rd_key | cell_key[i];
      end
    end
  end

  always_comb begin
    do_load   = 1'b0;
    do_evict  = 1'b0;
    do_remove = 1'b0;
    acc_nxt   = 1'b0;
    fnd_nxt   = 1'b0;
    ekey_nxt  = '0;
    pres_nxt  = 1'b0;
    fill_nxt  = fill_r;
    unique case (act)
      ulfe_pkg::ACT_INSERT: begin
        if (!req_null) begin
          if (any_match) begin
            fnd_nxt = 1'b1;
          end else if (fill_r < FILL_W'(CAPACITY)) begin
            do_load  = 1'b1;
            fill_nxt = fill_r + 1'b1;
            acc_nxt  = 1'b1;
          end else begin
            do_evict = 1'b1;
            acc_nxt  = 1'b1;
          end
        end
      end
      ulfe_pkg::ACT_LOOKUP: begin
        fnd_nxt = !req_null && any_match;
      end
      ulfe_pkg::ACT_REMOVE: begin
        if (idx_ok) begin
          ekey_nxt  = rd_key;
          pres_nxt  = 1'b1;
          do_remove = 1'b1;
          fill_nxt  = fill_r - 1'b1;
          acc_nxt   = 1'b1;
        end
      end
      ulfe_pkg::ACT_READ: begin
        if (idx_ok) begin
          ekey_nxt = rd_key;
          pres_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // evict feeds the new key in at the top, remove feeds in null
  assign top_in = do_evict ? req_key_r : '0;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_ctrl[i].load  = pend_r && do_load && (fill_r == FILL_W'(i));
      cell_ctrl[i].shift = pend_r && (do_evict || (do_remove && (idx_ext <= IW'(i))));
    end
  end

  assign occ_ext = OW'(fill_nxt);
  assign occ_nxt = (occ_ext > OW'(ulfe_pkg::OCC_MAX)) ?
                   ulfe_pkg::OCC_W'(ulfe_pkg::OCC_MAX) : occ_ext[ulfe_pkg::OCC_W-1:0];

  // ------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= accept;
      out_valid_r <= pend_r;
      if (pend_r) begin
        fill_r <= fill_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_act_r <= in_action;
      req_key_r <= in_host_key;
      req_idx_r <= in_slot_index;
    end
    if (pend_r) begin
      acc_r  <= acc_nxt;
      fnd_r  <= fnd_nxt;
      ekey_r <= ekey_nxt;
      pres_r <= pres_nxt;
      occ_r  <= occ_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_accepted      = acc_r;
  assign out_found         = fnd_r;
  assign out_entry_key     = ekey_r;
  assign out_entry_present = pres_r;
  assign out_occupancy     = occ_r;

  // ------------------------------------------------------------ assertions
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |=> out_valid_r)
    else $error("result strobe missing after request");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid_r))
    else $error("busy not raised after accept");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(CAPACITY))
    else $error("fill count beyond capacity");

  a_acc_fnd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(acc_r && fnd_r))
    else $error("accepted and found both set");

endmodule
